### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the top-level core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types and codes of the B-tree page core.
// ----------------------------------------------------------------------------
package btp_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_ROOT   = 2'd3;

    // result status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture item and per-cell compares
        logic exec;   // update the page and load the result
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;   // result register holds an item not taken this cycle
    } dp_status_t;

endpackage

### src/btp_stream_if.sv
// ----------------------------------------------------------------------------
// btp_stream_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface btp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [63:0]        key;
    logic signed [15:0] left_child;
    logic signed [15:0] right_child;

    modport source (output valid, operation, key, left_child, right_child, input ready);
    modport sink   (input valid, operation, key, left_child, right_child, output ready);
endinterface

interface btp_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [3:0]         position;
    logic signed [15:0] child_at_position;
    logic [3:0]         key_count;
    logic               status;

    modport source (output valid, found, position, child_at_position, key_count, status,
                    input ready);
    modport sink   (input valid, found, position, child_at_position, key_count, status,
                    output ready);
endinterface

### src/btp_ctrl.sv
// ----------------------------------------------------------------------------
// btp_ctrl
// Two-state sequencer: accept an item, then execute it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
module btp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  btp_pkg::dp_status_t   dp_stat,
    output btp_pkg::ctrl_cmd_t    cmd
);
    import btp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!dp_stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                // hold until the previous result is taken
                cmd.exec = !dp_stat.out_busy;
            end
            default: ;
        endcase
    end

endmodule

### src/btp_datapath.sv
// ----------------------------------------------------------------------------
// btp_datapath
// Key and child cells, per-cell compare, position encode, and result register.
// ----------------------------------------------------------------------------
module btp_datapath #(
    parameter int PAGE_KEYS  = 8,
    parameter int KEY_BYTES  = 8,
    parameter int CHILD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  btp_pkg::ctrl_cmd_t    cmd,
    output btp_pkg::dp_status_t   dp_stat,
    input  logic [1:0]            operation,
    input  logic [63:0]           key,
    input  logic signed [15:0]    left_child,
    input  logic signed [15:0]    right_child,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [3:0]            position,
    output logic signed [15:0]    child_at_position,
    output logic [3:0]            key_count,
    output logic                  res_status
);
    import btp_pkg::*;

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int CNT_W = $clog2(PAGE_KEYS + 1);
    localparam logic [CHILD_BITS-1:0] NONE_CHILD = '1;

    // page cells
    logic [KEY_W-1:0]      key_reg   [PAGE_KEYS];
    logic [KEY_W-1:0]      key_next  [PAGE_KEYS];
    logic [CHILD_BITS-1:0] child_reg [PAGE_KEYS+1];
    logic [CHILD_BITS-1:0] child_next[PAGE_KEYS+1];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // captured item and compare flags
    logic [1:0]            op_reg;
    logic [KEY_W-1:0]      kin_reg;
    logic [CHILD_BITS-1:0] lc_reg;
    logic [CHILD_BITS-1:0] rc_reg;
    logic [PAGE_KEYS-1:0]  lt_reg;
    logic [PAGE_KEYS-1:0]  le_reg;
    logic                  hit_reg;

    logic [KEY_W-1:0]      kin;
    logic [PAGE_KEYS-1:0]  lt_vec;
    logic [PAGE_KEYS-1:0]  eq_vec;

    // result register
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [3:0]            position_reg;
    logic [CHILD_BITS-1:0] child_out_reg;
    logic [3:0]            count_out_reg;
    logic                  status_reg;

    // execute-cycle signals
    logic [PAGE_KEYS-1:0]  thermo;
    logic [PAGE_KEYS:0]    pos_hot;
    logic [CNT_W-1:0]      pos;
    logic [CHILD_BITS-1:0] child_sel;
    logic                  full;
    logic                  do_ins;
    logic [CHILD_BITS-1:0] child_res;

    assign kin = key[KEY_W-1:0];

    // compare every valid cell with the incoming key
    always_comb
    begin
        for (int j = 0; j < PAGE_KEYS; j++) begin
            lt_vec[j] = (CNT_W'(j) < count_reg) && (key_reg[j] < kin);
            eq_vec[j] = (CNT_W'(j) < count_reg) && (key_reg[j] == kin);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            op_reg  <= operation;
            kin_reg <= kin;
            lc_reg  <= CHILD_BITS'(left_child);
            rc_reg  <= CHILD_BITS'(right_child);
            lt_reg  <= lt_vec;
            le_reg  <= lt_vec | eq_vec;
            hit_reg <= |eq_vec;
        end
    end

    // keys are sorted, so the flags form a prefix of ones; find its end
    assign thermo = (op_reg == OP_SEARCH) ? lt_reg : le_reg;

    always_comb
    begin
        pos_hot[0]         = ~thermo[0];
        pos_hot[PAGE_KEYS] = thermo[PAGE_KEYS-1];
        for (int p = 1; p < PAGE_KEYS; p++) begin
            pos_hot[p] = thermo[p-1] & ~thermo[p];
        end
    end

    always_comb
    begin
        pos       = '0;
        child_sel = '0;
        for (int p = 0; p <= PAGE_KEYS; p++) begin
            pos       = pos | (pos_hot[p] ? CNT_W'(p) : '0);
            child_sel = child_sel | (pos_hot[p] ? child_reg[p] : '0);
        end
    end

    assign full   = (count_reg == CNT_W'(PAGE_KEYS));
    assign do_ins = (op_reg == OP_INSERT) && !full;

    // next page contents
    always_comb
    begin
        for (int j = 0; j < PAGE_KEYS; j++) begin
            key_next[j] = key_reg[j];
        end
        for (int j = 0; j <= PAGE_KEYS; j++) begin
            child_next[j] = child_reg[j];
        end
        count_next = count_reg;
        unique case (op_reg)
            OP_CLEAR:
            begin
                for (int j = 0; j < PAGE_KEYS; j++) begin
                    key_next[j] = '0;
                end
                for (int j = 0; j <= PAGE_KEYS; j++) begin
                    child_next[j] = NONE_CHILD;
                end
                count_next = '0;
            end
            OP_SEARCH: ;
            OP_INSERT:
            begin
                if (do_ins) begin
                    if (pos == '0) begin
                        key_next[0] = kin_reg;
                    end
                    for (int j = 1; j < PAGE_KEYS; j++) begin
                        if (CNT_W'(j) == pos) begin
                            key_next[j] = kin_reg;
                        end
                        else if (CNT_W'(j) > pos && CNT_W'(j) <= count_reg) begin
                            key_next[j] = key_reg[j-1];
                        end
                    end
                    for (int j = 1; j <= PAGE_KEYS; j++) begin
                        if (CNT_W'(j - 1) == pos) begin
                            child_next[j] = rc_reg;
                        end
                        else if (CNT_W'(j - 1) > pos && CNT_W'(j - 1) <= count_reg) begin
                            child_next[j] = child_reg[j-1];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            OP_ROOT:
            begin
                for (int j = 0; j < PAGE_KEYS; j++) begin
                    key_next[j] = '0;
                end
                for (int j = 0; j <= PAGE_KEYS; j++) begin
                    child_next[j] = NONE_CHILD;
                end
                key_next[0]   = kin_reg;
                child_next[0] = lc_reg;
                child_next[1] = rc_reg;
                count_next    = CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_CLEAR:  child_res = NONE_CHILD;
            OP_ROOT:   child_res = lc_reg;
            default:   child_res = child_sel;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int j = 0; j < PAGE_KEYS; j++) begin
                key_reg[j] <= '0;
            end
            for (int j = 0; j <= PAGE_KEYS; j++) begin
                child_reg[j] <= NONE_CHILD;
            end
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cmd.exec) begin
                for (int j = 0; j < PAGE_KEYS; j++) begin
                    key_reg[j] <= key_next[j];
                end
                for (int j = 0; j <= PAGE_KEYS; j++) begin
                    child_reg[j] <= child_next[j];
                end
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec) begin
            found_reg     <= (op_reg == OP_SEARCH) && hit_reg;
            position_reg  <= ((op_reg == OP_SEARCH) || (op_reg == OP_INSERT)) ? 4'(pos) : 4'd0;
            child_out_reg <= child_res;
            count_out_reg <= 4'(count_next);
            status_reg    <= ((op_reg == OP_INSERT) && full) ? STATUS_FULL : STATUS_DONE;
        end
    end

    assign dp_stat.out_busy  = out_valid_reg && !out_ready;
    assign out_valid         = out_valid_reg;
    assign found             = found_reg;
    assign position          = position_reg;
    assign child_at_position = 16'(signed'(child_out_reg));
    assign key_count         = count_out_reg;
    assign res_status        = status_reg;

endmodule

### src/btree_page_sorted_insert_search_core.sv
// ----------------------------------------------------------------------------
// btree_page_sorted_insert_search_core
// One B-tree page with clear, search, insert and make-root operations.
// ----------------------------------------------------------------------------
// Each request item has an accept cycle and then an execute cycle: in the
// accept cycle every key cell compares its key with the incoming key and the
// flags are registered; in the execute cycle the flags are encoded into a
// position, the key and child cells shift in place, and the response item is
// loaded into the output register. The execute cycle waits while an earlier
// response item is still held; no new item is accepted until the current one
// has executed, as the compare is registered between accept and update. The
// page resets directly into the cleared state (no keys, all children none),
// with no clearing pass. Keys compare as unsigned values of their low
// KEY_BYTES bytes; an insert into a full page leaves it unchanged and reports
// status full with the position where the key would have gone.
`include "assert_macros.svh"

module btree_page_sorted_insert_search_core #(
    parameter int PAGE_KEYS  = 8,
    parameter int KEY_BYTES  = 8,
    parameter int CHILD_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    btp_req_if.sink    request,
    btp_rsp_if.source  response
);
    import btp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    // sequencer: accept, then execute
    btp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    // page cells and result register
    btp_datapath #(
        .PAGE_KEYS  (PAGE_KEYS),
        .KEY_BYTES  (KEY_BYTES),
        .CHILD_BITS (CHILD_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .dp_stat           (dp_stat),
        .operation         (request.operation),
        .key               (request.key),
        .left_child        (request.left_child),
        .right_child       (request.right_child),
        .out_valid         (response.valid),
        .out_ready         (response.ready),
        .found             (response.found),
        .position          (response.position),
        .child_at_position (response.child_at_position),
        .key_count         (response.key_count),
        .res_status        (response.status)
    );

    // one item in flight: after an accept, no second accept next cycle
    `ASSERT_NEXT(a_single_item, clk, rst_n, request.valid && request.ready, !request.ready)

    // never accept and execute in the same cycle
    `ASSERT_IMPL(a_no_overlap, clk, rst_n, request.ready, !cmd.exec)

    // a response item appears only after an execute cycle
    `ASSERT_IMPL(a_rsp_from_exec, clk, rst_n, $rose(response.valid), $past(cmd.exec))

endmodule
